// File: hdl/bdms_pkg.sv
// bdms_pkg: shared types and constants for the button debounce / mode select block.
// No dependencies; used by the config interface and all modules.
package bdms_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int STEP_W      = 8;
	localparam int PERIOD_W    = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// button order inside sample vectors
	localparam int BTN_MODE  = 0;
	localparam int BTN_PLUS  = 1;
	localparam int BTN_MINUS = 2;

	typedef enum logic [1:0] {
		BTN_IDLE    = 2'd0,
		BTN_PRE     = 2'd1,
		BTN_PRESSED = 2'd2,
		BTN_POST    = 2'd3
	} btn_state_t;

	typedef enum logic [1:0] {
		MODE_WATCH     = 2'd0,
		MODE_SET       = 2'd1,
		MODE_STOPWATCH = 2'd2
	} run_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_STEP     = 2'd0,
		REG_SAMPLE_PERIOD = 2'd1,
		REG_PUSHED_LEVEL  = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_reg_t;

	localparam logic [STEP_W-1:0]   TICK_STEP_RST     = 8'd1;
	localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd20;
	localparam logic                PUSHED_LEVEL_RST  = 1'b1;

	typedef struct packed {
		logic [STEP_W-1:0]   tick_step;
		logic [PERIOD_W-1:0] sample_period;
		logic                pushed_level;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode_button_state;
		logic [1:0] plus_button_state;
		logic [1:0] minus_button_state;
		logic [1:0] run_mode;
		logic       sampled;
	} result_t;

	typedef struct packed {
		logic main_v;
		logic skid_v;
	} buf_stat_t;

endpackage

// File: hdl/bdms_ifs.sv
// bdms channel interfaces: tick requests in, results out, config writes.
// Depends on bdms_pkg for widths.
interface bdms_tick_if;
	logic valid;
	logic ready;
	logic raw_mode_button;
	logic raw_plus_button;
	logic raw_minus_button;
	modport source (output valid, raw_mode_button, raw_plus_button, raw_minus_button,
		input ready);
	modport sink (input valid, raw_mode_button, raw_plus_button, raw_minus_button,
		output ready);
endinterface

interface bdms_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode_button_state;
	logic [1:0] plus_button_state;
	logic [1:0] minus_button_state;
	logic [1:0] run_mode;
	logic       sampled;
	modport source (output valid, mode_button_state, plus_button_state, minus_button_state,
		run_mode, sampled, input ready);
	modport sink (input valid, mode_button_state, plus_button_state, minus_button_state,
		run_mode, sampled, output ready);
endinterface

interface bdms_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bdms_pkg::CFG_IDX_W-1:0]  index;
	logic [bdms_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/bdms_debounce.sv
// bdms_debounce: four-state debounce next-state logic for one button.
// Depends on bdms_pkg (btn_state_t).
module bdms_debounce (
	input  bdms_pkg::btn_state_t state,
	input  logic                 older,
	input  logic                 newer,
	output bdms_pkg::btn_state_t next
);
	logic both_pushed;
	logic both_released;

	assign both_pushed   = older & newer;
	assign both_released = ~older & ~newer;

	always_comb begin
		unique case (state)
			bdms_pkg::BTN_IDLE:    next = both_pushed ? bdms_pkg::BTN_PRE : bdms_pkg::BTN_IDLE;
			bdms_pkg::BTN_PRE:     next = both_pushed ? bdms_pkg::BTN_PRESSED : bdms_pkg::BTN_PRE;
			bdms_pkg::BTN_PRESSED: next = both_released ? bdms_pkg::BTN_POST
				: bdms_pkg::BTN_PRESSED;
			default:               next = both_released ? bdms_pkg::BTN_IDLE : bdms_pkg::BTN_POST;
		endcase
	end
endmodule

// File: hdl/bdms_core.sv
// bdms_core: tick accumulator, sample shift registers, debounce states, mode counter.
// Depends on bdms_pkg and bdms_debounce.
module bdms_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [bdms_pkg::NUM_BUTTONS-1:0]  raw,
	input  bdms_pkg::cfg_t                     cfg,
	output bdms_pkg::result_t                  result
);
	logic [bdms_pkg::PERIOD_W-1:0]    acc_q;
	logic [bdms_pkg::NUM_BUTTONS-1:0] cur_q;
	bdms_pkg::btn_state_t             st_q   [bdms_pkg::NUM_BUTTONS];
	bdms_pkg::btn_state_t             st_nxt [bdms_pkg::NUM_BUTTONS];
	bdms_pkg::run_mode_t              mode_q;
	bdms_pkg::run_mode_t              mode_nxt;
	logic [bdms_pkg::PERIOD_W:0]      sum;
	logic                             hit;
	logic [bdms_pkg::NUM_BUTTONS-1:0] fresh;

	// 17-bit sum so a carry still counts as reaching the period
	assign sum   = {1'b0, acc_q} + {{(bdms_pkg::PERIOD_W + 1 - bdms_pkg::STEP_W){1'b0}},
		cfg.tick_step};
	assign hit   = (sum >= {1'b0, cfg.sample_period});
	assign fresh = ~(raw ^ {bdms_pkg::NUM_BUTTONS{cfg.pushed_level}});

	// older sample is the one held now, newer is the one being taken
	genvar g;
	generate
		for (g = 0; g < bdms_pkg::NUM_BUTTONS; g++) begin : g_btn
			bdms_debounce u_deb (
				.state (st_q[g]),
				.older (cur_q[g]),
				.newer (fresh[g]),
				.next  (st_nxt[g])
			);
		end
	endgenerate

	always_comb begin
		unique case (mode_q)
			bdms_pkg::MODE_WATCH: mode_nxt = bdms_pkg::MODE_SET;
			bdms_pkg::MODE_SET:   mode_nxt = bdms_pkg::MODE_STOPWATCH;
			default:              mode_nxt = bdms_pkg::MODE_WATCH;
		endcase
	end

	// result as it will stand after this request
	always_comb begin
		result.sampled = hit;
		if (hit) begin
			result.mode_button_state  = st_nxt[bdms_pkg::BTN_MODE];
			result.plus_button_state  = st_nxt[bdms_pkg::BTN_PLUS];
			result.minus_button_state = st_nxt[bdms_pkg::BTN_MINUS];
			result.run_mode           = (st_q[bdms_pkg::BTN_MODE] == bdms_pkg::BTN_PRE)
				? mode_nxt : mode_q;
		end else begin
			result.mode_button_state  = st_q[bdms_pkg::BTN_MODE];
			result.plus_button_state  = st_q[bdms_pkg::BTN_PLUS];
			result.minus_button_state = st_q[bdms_pkg::BTN_MINUS];
			result.run_mode           = mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cur_q  <= '0;
			mode_q <= bdms_pkg::MODE_WATCH;
			for (int i = 0; i < bdms_pkg::NUM_BUTTONS; i++) begin
				st_q[i] <= bdms_pkg::BTN_IDLE;
			end
		end else if (step) begin
			if (hit) begin
				acc_q  <= '0;
				cur_q  <= fresh;
				mode_q <= bdms_pkg::run_mode_t'(result.run_mode);
				for (int i = 0; i < bdms_pkg::NUM_BUTTONS; i++) begin
					st_q[i] <= st_nxt[i];
				end
			end else begin
				acc_q <= sum[bdms_pkg::PERIOD_W-1:0];
			end
		end
	end
endmodule

// File: hdl/bdms_out_buf.sv
// bdms_out_buf: two-entry result buffer (output register plus skid register).
// Depends on bdms_pkg (result_t, buf_stat_t).
module bdms_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bdms_pkg::result_t   din,
	input  logic                pop,
	output bdms_pkg::result_t   dout,
	output bdms_pkg::buf_stat_t stat
);
	bdms_pkg::result_t main_q;
	bdms_pkg::result_t skid_q;
	logic              main_v_q;
	logic              skid_v_q;

	assign dout        = main_q;
	assign stat.main_v = main_v_q;
	assign stat.skid_v = skid_v_q;

	// push only happens while skid is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push && pop) begin
				main_v_q <= 1'b1;
			end else if (push) begin
				if (main_v_q) begin
					skid_v_q <= 1'b1;
				end else begin
					main_v_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					main_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && (pop || !main_v_q)) begin
			main_q <= din;
		end else if (push) begin
			skid_q <= din;
		end else if (pop && skid_v_q) begin
			main_q <= skid_q;
		end
	end
endmodule

// File: hdl/button_debounce_mode_select.sv
// button_debounce_mode_select: three-button debouncer with a mode selector.
// Depends on bdms_pkg, bdms_ifs, bdms_core, bdms_debounce and bdms_out_buf.
//
//  channel | role   | moves
//  --------+--------+------------------------------------------------------
//  tick    | sink   | one timer tick request: raw mode / plus / minus levels
//  res     | source | debounce states, run mode, sampled flag per tick
//  cfg     | sink   | register write: index, data (always ready)
//
// One tick request is taken per cycle while the buffer has room; its result is written into the buffer then.
// The rate is set by the single state update in bdms_core (accumulator add
// and compare, three debounce FSMs, mode counter), done in the accept cycle.
// Results queue in a two-entry buffer, so a tick is still taken while one
// result waits; tick.ready drops only when both entries are full.
// Asynchronous reset clears the core state and buffer valid flags and loads the register reset values.
module button_debounce_mode_select (
	input  logic         clk,
	input  logic         arst_n,
	bdms_tick_if.sink    tick,
	bdms_res_if.source   res,
	bdms_cfg_if.sink     cfg
);
	bdms_pkg::cfg_t      cfg_q;
	bdms_pkg::result_t   core_res;
	bdms_pkg::result_t   buf_res;
	bdms_pkg::buf_stat_t stat;
	logic                tick_acc;
	logic                res_acc;
	logic [bdms_pkg::NUM_BUTTONS-1:0] raw;

	// ---- configuration registers ----
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_step     <= bdms_pkg::TICK_STEP_RST;
			cfg_q.sample_period <= bdms_pkg::SAMPLE_PERIOD_RST;
			cfg_q.pushed_level  <= bdms_pkg::PUSHED_LEVEL_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (bdms_pkg::cfg_reg_t'(cfg.index))
				bdms_pkg::REG_TICK_STEP:     cfg_q.tick_step <= cfg.data[bdms_pkg::STEP_W-1:0];
				bdms_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg.data;
				bdms_pkg::REG_PUSHED_LEVEL:  cfg_q.pushed_level <= cfg.data[0];
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	// ---- tick handshake ----
	// ready only depends on the skid entry, not on res.ready
	assign tick.ready = !stat.skid_v;
	assign tick_acc   = tick.valid && tick.ready;
	assign res_acc    = res.valid && res.ready;

	// sample vector layout: bit 0 mode, bit 1 plus, bit 2 minus
	assign raw[bdms_pkg::BTN_MODE]  = tick.raw_mode_button;
	assign raw[bdms_pkg::BTN_PLUS]  = tick.raw_plus_button;
	assign raw[bdms_pkg::BTN_MINUS] = tick.raw_minus_button;

	bdms_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick_acc),
		.raw    (raw),
		.cfg    (cfg_q),
		.result (core_res)
	);

	bdms_out_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tick_acc),
		.din    (core_res),
		.pop    (res_acc),
		.dout   (buf_res),
		.stat   (stat)
	);

	// ---- result channel ----
	assign res.valid              = stat.main_v;
	assign res.mode_button_state  = buf_res.mode_button_state;
	assign res.plus_button_state  = buf_res.plus_button_state;
	assign res.minus_button_state = buf_res.minus_button_state;
	assign res.run_mode           = buf_res.run_mode;
	assign res.sampled            = buf_res.sampled;

	// ---- assertions ----
	// skid entry is never occupied with the main entry empty
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		stat.skid_v |-> stat.main_v)
		else $error("skid entry valid while output entry empty");

	// a request taken into an empty buffer shows up on the next cycle
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc && !stat.main_v |=> stat.main_v)
		else $error("accepted tick did not produce a result");

	// a full, stalled buffer stays full
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat.skid_v && !res.ready |=> stat.skid_v)
		else $error("buffered result lost under stall");

	// mode counter never reaches the unused code
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.run_mode <= bdms_pkg::MODE_STOPWATCH))
		else $error("run mode out of range");
endmodule

// File: tb/button_debounce_mode_select_test.sv
// Regression bench for button_debounce_mode_select: directed and random tick requests,
// register writes between phases, checks every result against a cycle-free predictor.
// Depends on bdms_pkg, bdms_ifs and the button_debounce_mode_select RTL.
`timescale 1ns / 1ps

module button_debounce_mode_select_test;

	localparam int STALL_LIMIT = 2000;   // cycles with no handshake anywhere
	localparam int DRAIN_WAIT  = 4;      // settle time once the two-entry output buffer has emptied
	localparam int MAX_PRINTS  = 30;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bdms_tick_if tick();
	bdms_res_if  res();
	bdms_cfg_if  cfg();

	button_debounce_mode_select dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.res    (res),
		.cfg    (cfg)
	);

	// register copies, reset values
	logic [bdms_pkg::STEP_W-1:0]   step_cfg   = bdms_pkg::TICK_STEP_RST;
	logic [bdms_pkg::PERIOD_W-1:0] period_cfg = bdms_pkg::SAMPLE_PERIOD_RST;
	logic                          level_cfg  = bdms_pkg::PUSHED_LEVEL_RST;

	// predictor state; bit b of the sample vectors is pushed/not for button b
	logic [bdms_pkg::PERIOD_W-1:0] tick_acc    = '0;
	logic [2:0]                    prev_pushed = '0;
	logic [2:0]                    cur_pushed  = '0;
	bdms_pkg::btn_state_t          btn_st [bdms_pkg::NUM_BUTTONS] =
		'{bdms_pkg::BTN_IDLE, bdms_pkg::BTN_IDLE, bdms_pkg::BTN_IDLE};
	bdms_pkg::run_mode_t           mode_sel    = bdms_pkg::MODE_WATCH;

	bdms_pkg::result_t expected_results [$];
	int      error_count = 0;
	bit      calm        = 1'b0;   // when set, neither side takes random gaps
	int      hold_cycles = 0;      // long receiver hold-off, picked up by result_sink

	// One timer tick: advance the accumulator, sample and debounce on reaching the period.
	function automatic bdms_pkg::result_t debounce_tick(input logic [2:0] raw);
		bdms_pkg::result_t r;
		int unsigned       total;
		logic              both_on, both_off;
		r = '0;
		total = tick_acc + step_cfg;
		if (total >= period_cfg) begin
			tick_acc  = '0;
			r.sampled = 1'b1;
			// mode counter looks at the mode button state before this sample
			if (btn_st[bdms_pkg::BTN_MODE] == bdms_pkg::BTN_PRE)
				mode_sel = (mode_sel == bdms_pkg::MODE_STOPWATCH) ? bdms_pkg::MODE_WATCH :
					bdms_pkg::run_mode_t'(mode_sel + 2'd1);
			prev_pushed = cur_pushed;
			for (int b = 0; b < bdms_pkg::NUM_BUTTONS; b++)
				cur_pushed[b] = (raw[b] == level_cfg);
			for (int b = 0; b < bdms_pkg::NUM_BUTTONS; b++) begin
				both_on  = prev_pushed[b] & cur_pushed[b];
				both_off = ~prev_pushed[b] & ~cur_pushed[b];
				case (btn_st[b])
					bdms_pkg::BTN_IDLE:    if (both_on)  btn_st[b] = bdms_pkg::BTN_PRE;
					bdms_pkg::BTN_PRE:     if (both_on)  btn_st[b] = bdms_pkg::BTN_PRESSED;
					bdms_pkg::BTN_PRESSED: if (both_off) btn_st[b] = bdms_pkg::BTN_POST;
					default:               if (both_off) btn_st[b] = bdms_pkg::BTN_IDLE;
				endcase
			end
		end else begin
			tick_acc = total[bdms_pkg::PERIOD_W-1:0];
		end
		r.mode_button_state  = btn_st[bdms_pkg::BTN_MODE];
		r.plus_button_state  = btn_st[bdms_pkg::BTN_PLUS];
		r.minus_button_state = btn_st[bdms_pkg::BTN_MINUS];
		r.run_mode           = mode_sel;
		return r;
	endfunction

	function automatic int pick_gap();
		return calm ? 0 : int'($urandom_range(0, 15));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Offer one tick request. Valid is left high on return so a zero gap keeps
	// it asserted; it is lowered here (or in drain_results) in the accept step.
	task automatic send_tick(input logic [2:0] raw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick.valid            <= 1'b1;
		tick.raw_mode_button  <= raw[bdms_pkg::BTN_MODE];
		tick.raw_plus_button  <= raw[bdms_pkg::BTN_PLUS];
		tick.raw_minus_button <= raw[bdms_pkg::BTN_MINUS];
		@(posedge clk);
		while (tick.ready !== 1'b1) @(posedge clk);
		expected_results.push_back(debounce_tick(raw));
	endtask

	// Stop offering, wait for every result, then let the pipeline settle.
	task automatic drain_results();
		tick.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_reg(input bdms_pkg::cfg_reg_t idx,
		input logic [bdms_pkg::CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (cfg.ready !== 1'b1) @(posedge clk);
		case (idx)
			bdms_pkg::REG_TICK_STEP:     step_cfg   = value[bdms_pkg::STEP_W-1:0];
			bdms_pkg::REG_SAMPLE_PERIOD: period_cfg = value[bdms_pkg::PERIOD_W-1:0];
			bdms_pkg::REG_PUSHED_LEVEL:  level_cfg  = value[0];
			default: ;   // unused index is dropped by the block
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	// Reset settings: step 1, period 20, so a handful of ticks never samples.
	task automatic test_reset_values();
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b000);
		drain_results();
	endtask

	// Period 1 samples on every tick: walk all buttons through the full
	// press/release cycle; the mode press advances the run mode.
	// Period 1 lies below the accumulator left by the reset test.
	task automatic test_press_release();
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'd1);
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b000);
		send_tick(3'b000);
		send_tick(3'b000);
		send_tick(3'b010);
		send_tick(3'b101);
		send_tick(3'b101);
		drain_results();
	endtask

	// Pull-up wiring: low means pushed. Upper data bits must be ignored.
	task automatic test_pull_up();
		write_reg(bdms_pkg::REG_PUSHED_LEVEL, 16'hFFFE);
		send_tick(3'b000);
		send_tick(3'b000);
		send_tick(3'b000);
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b111);
		drain_results();
	endtask

	// Zero period, zero step, unused index, register extremes, and a period
	// lowered below the running accumulator.
	task automatic test_special_periods();
		write_reg(bdms_pkg::REG_TICK_STEP, 16'hAB00);      // step 0 after truncation
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'd0);     // every tick samples
		send_tick(3'b110);
		send_tick(3'b110);
		drain_results();
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'd5);     // step 0: never samples
		send_tick(3'b011);
		send_tick(3'b011);
		drain_results();
		write_reg(bdms_pkg::REG_UNUSED, 16'h1234);
		write_reg(bdms_pkg::REG_TICK_STEP, 16'h00FF);
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'hFFFF);
		write_reg(bdms_pkg::REG_PUSHED_LEVEL, 16'h0001);
		send_tick(3'b111);
		drain_results();
		write_reg(bdms_pkg::REG_TICK_STEP, 16'd200);
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'd1000);
		send_tick(3'b001);
		send_tick(3'b001);
		drain_results();
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'd100);   // accumulator already past it
		send_tick(3'b001);
		drain_results();
	endtask

	// Random phases: new settings each phase, button levels held in runs so
	// the debounce machines get through all four states, with rare glitches.
	task automatic test_random_phases();
		logic [bdms_pkg::STEP_W-1:0]   step;
		logic [bdms_pkg::PERIOD_W-1:0] period;
		logic [2:0]                    held, raw;
		int                            sel, pick;
		held = '0;
		for (int phase = 0; phase < 20; phase++) begin
			sel = (phase < 4) ? phase : int'($urandom_range(0, 9));
			case (sel)
				0: begin step = 8'd255; period = 16'hFFFF; end
				1: begin step = 8'd1;   period = 16'hFFFF; end
				2: begin step = 8'($urandom); period = 16'd0; end
				3: begin step = 8'd0;   period = 16'($urandom_range(1, 20)); end
				4: begin
					step   = 8'($urandom_range(1, 255));
					period = 16'($urandom_range(1, 600));
				end
				default: begin
					step   = 8'($urandom_range(1, 3));
					period = 16'($urandom_range(0, 6));
				end
			endcase
			write_reg(bdms_pkg::REG_TICK_STEP, {8'($urandom), step});
			write_reg(bdms_pkg::REG_SAMPLE_PERIOD, period);
			write_reg(bdms_pkg::REG_PUSHED_LEVEL, {15'($urandom), 1'($urandom)});
			if ($urandom_range(0, 3) == 0)
				write_reg(bdms_pkg::REG_UNUSED, 16'($urandom));
			calm = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < 95; k++) begin
				for (int b = 0; b < bdms_pkg::NUM_BUTTONS; b++)
					if ($urandom_range(0, 4) == 0) held[b] = ~held[b];
				raw = held;
				if ($urandom_range(0, 15) == 0) begin
					pick = int'($urandom_range(0, bdms_pkg::NUM_BUTTONS - 1));
					raw[pick] = ~raw[pick];
				end
				send_tick(raw);
			end
			drain_results();
		end
		calm = 1'b0;
	endtask

	// Receiver holds off for a long stretch while ticks keep coming, so the
	// output buffer fills and tick.ready drops.
	task automatic test_backpressure();
		write_reg(bdms_pkg::REG_TICK_STEP, 16'd1);
		write_reg(bdms_pkg::REG_SAMPLE_PERIOD, 16'd2);
		calm = 1'b1;
		hold_cycles = 300;
		for (int k = 0; k < 40; k++)
			send_tick(3'($urandom));
		drain_results();
		calm = 1'b0;
	endtask

	// ---------------------------------------------------------------- result side

	// Ready with a random stall per result; takes a long hold-off when asked.
	initial begin : result_sink
		int stall, held_off;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				held_off = hold_cycles;
				hold_cycles = 0;
				res.ready <= 1'b0;
				repeat (held_off) @(posedge clk);
			end
			stall = pick_gap();
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (res.valid !== 1'b1) @(posedge clk);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		bdms_pkg::result_t want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", res.sampled, 0);
			end else begin
				want = expected_results.pop_front();
				if (res.mode_button_state !== want.mode_button_state)
					report_mismatch("mode_button_state", res.mode_button_state,
						want.mode_button_state);
				if (res.plus_button_state !== want.plus_button_state)
					report_mismatch("plus_button_state", res.plus_button_state,
						want.plus_button_state);
				if (res.minus_button_state !== want.minus_button_state)
					report_mismatch("minus_button_state", res.minus_button_state,
						want.minus_button_state);
				if (res.run_mode !== want.run_mode)
					report_mismatch("run_mode", res.run_mode, want.run_mode);
				if (res.sampled !== want.sampled)
					report_mismatch("sampled", res.sampled, want.sampled);
			end
		end
	end

	// Watchdog: a stretch without a handshake on any channel that reaches STALL_LIMIT fails the run.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick.valid && tick.ready) || (res.valid && res.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("button_debounce_mode_select regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n                <= 1'b0;
		tick.valid            <= 1'b0;
		tick.raw_mode_button  <= 1'b0;
		tick.raw_plus_button  <= 1'b0;
		tick.raw_minus_button <= 1'b0;
		cfg.valid             <= 1'b0;
		cfg.index             <= bdms_pkg::REG_TICK_STEP;
		cfg.data              <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_press_release();
		test_pull_up();
		test_special_periods();
		test_random_phases();
		test_backpressure();

		drain_results();
		if (error_count == 0)
			$display("button_debounce_mode_select regression: pass");
		else
			$display("button_debounce_mode_select regression: fail");
		$finish;
	end

endmodule
